[rtl/core/b64e_pkg.sv]
// ---------------------------------------------------------------------------
// b64e_pkg: shared types and constants of the Base64 encoder
// Holds the shuffled alphabet, the padding code and the group record that
// the front part hands to the back part.
// ---------------------------------------------------------------------------
package b64e_pkg;

	localparam logic [7:0] PAD_CHAR = 8'h3D;
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] ALPHABET [64] = '{
		"Q", "V", "E", "J", "A", "f", "H", "m",
		"U", "Y", "j", "B", "a", "c", "+", "u",
		"8", "P", "h", "5", "n", "9", "O", "d",
		"1", "6", "F", "r", "I", "C", "L", "/",
		"X", "0", "G", "v", "t", "M", "4", "q",
		"k", "7", "T", "2", "z", "3", "w", "N",
		"S", "s", "y", "o", "e", "b", "i", "l",
		"x", "W", "K", "g", "Z", "p", "R", "D"
	};

	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_SECOND = 2'd1,
		PH_THIRD  = 2'd2
	} phase_t;

	typedef struct packed {
		logic       pad;
		logic [5:0] idx;
	} sym_t;

	typedef struct packed {
		sym_t [3:0] syms;
		logic [1:0] last_pos;
		logic       last;
	} grp_t;

	typedef struct packed {
		logic valid;
		logic full;
	} qstat_t;

	function automatic logic [7:0] sym_char(input sym_t s);
		return s.pad ? PAD_CHAR : ALPHABET[s.idx];
	endfunction

endpackage

[rtl/core/b64e_byte_if.sv]
// ---------------------------------------------------------------------------
// b64e_byte_if: byte channel
// Carries one message byte and its end-of-message flag per transfer.
// ---------------------------------------------------------------------------
interface b64e_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, data_byte, last_byte, input ready);
	modport sink(input valid, data_byte, last_byte, output ready);
endinterface

[rtl/core/b64e_char_if.sv]
// ---------------------------------------------------------------------------
// b64e_char_if: character channel
// Carries one encoded character and its end-of-message flag per transfer.
// ---------------------------------------------------------------------------
interface b64e_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       out_last;

	modport source(output valid, out_char, out_last, input ready);
	modport sink(input valid, out_char, out_last, output ready);
endinterface

[rtl/core/b64e_front.sv]
// ---------------------------------------------------------------------------
// b64e_front: byte intake and group split
// Tracks the position in the 3-byte group and the leftover bits, and turns
// each byte into a record of one to four alphabet indices or pad marks.
// ---------------------------------------------------------------------------
module b64e_front (
	input  logic                clk,
	input  logic                arst_n,
	b64e_byte_if.sink           bytes,
	input  b64e_pkg::qstat_t    qstat,
	output logic                push,
	output b64e_pkg::grp_t      push_grp
);
	import b64e_pkg::*;

	phase_t     phase_q, phase_d;
	logic [3:0] left_q, left_d;
	logic [7:0] b;

	assign b = bytes.data_byte;
	assign bytes.ready = !qstat.full;
	assign push = bytes.valid && bytes.ready;

	always_comb begin
		push_grp = '0;
		push_grp.last = bytes.last_byte;
		phase_d = phase_q;
		left_d = left_q;
		unique case (phase_q)
			PH_SECOND: begin
				push_grp.syms[0].idx = {left_q[1:0], b[7:4]};
				push_grp.syms[1].idx = {b[3:0], 2'b00};
				push_grp.syms[2].pad = 1'b1;
				push_grp.last_pos = bytes.last_byte ? 2'd2 : 2'd0;
				phase_d = PH_THIRD;
				left_d = b[3:0];
			end
			PH_THIRD: begin
				push_grp.syms[0].idx = {left_q, b[7:6]};
				push_grp.syms[1].idx = b[5:0];
				push_grp.last_pos = 2'd1;
				phase_d = PH_FIRST;
				left_d = '0;
			end
			default: begin
				push_grp.syms[0].idx = b[7:2];
				push_grp.syms[1].idx = {b[1:0], 4'b0000};
				push_grp.syms[2].pad = 1'b1;
				push_grp.syms[3].pad = 1'b1;
				push_grp.last_pos = bytes.last_byte ? 2'd3 : 2'd0;
				phase_d = PH_SECOND;
				left_d = {2'b00, b[1:0]};
			end
		endcase
		if (bytes.last_byte) begin
			phase_d = PH_FIRST;
			left_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			left_q <= '0;
		end else if (push) begin
			phase_q <= phase_d;
			left_q <= left_d;
		end
	end

endmodule

[rtl/core/b64e_queue.sv]
// ---------------------------------------------------------------------------
// b64e_queue: group record queue
// A two-entry queue that decouples byte intake from character output.
// ---------------------------------------------------------------------------
module b64e_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  b64e_pkg::grp_t      push_grp,
	input  logic                pop,
	output b64e_pkg::qstat_t    qstat,
	output b64e_pkg::grp_t      head
);
	import b64e_pkg::*;

	grp_t              mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign qstat.valid = cnt_q != '0;
	assign qstat.full = cnt_q == QCNT_W'(QDEPTH);
	assign head = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/b64e_back.sv]
// ---------------------------------------------------------------------------
// b64e_back: character serializer
// Walks the head record one symbol per cycle unless the output stalls,
// maps it through the alphabet and holds the character in the output register.
// ---------------------------------------------------------------------------
module b64e_back (
	input  logic                clk,
	input  logic                arst_n,
	input  b64e_pkg::qstat_t    qstat,
	input  b64e_pkg::grp_t      head,
	output logic                pop,
	b64e_char_if.source         chars
);
	import b64e_pkg::*;

	logic [1:0] pos_q;
	logic       valid_q;
	logic [7:0] char_q;
	logic       last_q;
	logic       adv;
	logic       at_end;

	assign adv = !valid_q || chars.ready;
	assign at_end = pos_q == head.last_pos;
	assign pop = adv && qstat.valid && at_end;

	assign chars.valid = valid_q;
	assign chars.out_char = char_q;
	assign chars.out_last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= qstat.valid;
			if (qstat.valid) begin
				pos_q <= at_end ? 2'd0 : pos_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && qstat.valid) begin
			char_q <= sym_char(head.syms[pos_q]);
			last_q <= head.last && at_end;
		end
	end

endmodule

[rtl/core/base64_encoder_custom_alphabet.sv]
// ---------------------------------------------------------------------------
// base64_encoder_custom_alphabet: streaming Base64 encoder
// Encodes a byte stream with a fixed shuffled alphabet and '=' padding.
// ---------------------------------------------------------------------------
// One byte is taken per transfer and split at once into a record of one to
// four symbols, which waits in a two-entry queue; the output side sends one
// character per cycle while chars.ready is not held low. A byte yields one
// or two characters inside a message, three or four when it is the last
// byte of an unfinished group; in a long message that is four characters
// per three bytes, and the character serializer sets the throughput.
// A byte flagged last ends the message, and the final character is flagged.
module base64_encoder_custom_alphabet (
	input  logic          clk,
	input  logic          arst_n,
	b64e_byte_if.sink     bytes,
	b64e_char_if.source   chars
);
	import b64e_pkg::*;

	qstat_t qstat;
	logic   push;
	logic   pop;
	grp_t   push_grp;
	grp_t   head;

	b64e_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.bytes    (bytes),
		.qstat    (qstat),
		.push     (push),
		.push_grp (push_grp)
	);

	b64e_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_grp (push_grp),
		.pop      (pop),
		.qstat    (qstat),
		.head     (head)
	);

	b64e_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.head   (head),
		.pop    (pop),
		.chars  (chars)
	);

`ifndef SYNTHESIS
	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full |-> qstat.valid)
		else $error("queue full without a head entry");

	a_pad_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(chars.valid && chars.ready && chars.out_char == PAD_CHAR && !chars.out_last)
		|=> (chars.valid && chars.out_char == PAD_CHAR && chars.out_last))
		else $error("leading pad not followed by final pad");

	a_last_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(bytes.valid && bytes.ready && bytes.last_byte) |=> qstat.valid)
		else $error("final byte transfer left the queue empty");
`endif

endmodule

[sim/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top: testbench of the streaming Base64 encoder
// Sends whole messages of bytes and checks every encoded character and its
// end flag against an encoder model kept in the bench, or against the fixed
// characters given in a table row. A short table of fixed messages comes
// first, then random messages, with random gaps and stalls on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import b64e_pkg::*;

	localparam logic [511:0] ENC_TABLE =
		"QVEJAfHmUYjBac+u8Ph5n9Od16FrICL/X0GvtM4qk7T2z3wNSsyoebilxWKgZpRD";
	localparam int unsigned RANDOM_BYTES = 400;
	localparam int unsigned DIR_ROWS = 24;

	typedef struct packed {
		logic [7:0]  ch;
		logic        last;
	} enc_char_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic [2:0]  known_n;
		logic [31:0] known;
	} msg_row_t;

	// Rows with a count of zero are checked against the encoder model.
	localparam msg_row_t MSG_TABLE [DIR_ROWS] = '{
		'{8'h00, 1'b1, 3'd4, "QQ=="},
		'{8'hFF, 1'b1, 3'd4, "DS=="},
		'{8'h00, 1'b0, 3'd1, "Q"},
		'{8'h00, 1'b1, 3'd3, "QQ="},
		'{8'hFF, 1'b0, 3'd1, "D"},
		'{8'hFF, 1'b1, 3'd3, "DZ="},
		'{8'h00, 1'b0, 3'd1, "Q"},
		'{8'h00, 1'b0, 3'd1, "Q"},
		'{8'h00, 1'b1, 3'd2, "QQ"},
		'{8'hFF, 1'b0, 3'd1, "D"},
		'{8'hFF, 1'b0, 3'd1, "D"},
		'{8'hFF, 1'b1, 3'd2, "DD"},
		'{8'h4D, 1'b0, 3'd0, 32'h0},
		'{8'h61, 1'b0, 3'd0, 32'h0},
		'{8'h6E, 1'b0, 3'd0, 32'h0},
		'{8'h80, 1'b1, 3'd0, 32'h0},
		'{8'h55, 1'b0, 3'd0, 32'h0},
		'{8'hAA, 1'b0, 3'd0, 32'h0},
		'{8'h5A, 1'b0, 3'd0, 32'h0},
		'{8'hA5, 1'b0, 3'd0, 32'h0},
		'{8'h3C, 1'b1, 3'd0, 32'h0},
		'{8'h01, 1'b0, 3'd0, 32'h0},
		'{8'h80, 1'b0, 3'd0, 32'h0},
		'{8'h7F, 1'b1, 3'd0, 32'h0}
	};

	logic clk;
	logic arst_n;

	b64e_byte_if bytes_if ();
	b64e_char_if chars_if ();

	base64_encoder_custom_alphabet dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes_if),
		.chars  (chars_if)
	);

	enc_char_t   pending_chars [$];
	int unsigned mismatch_count = 0;
	logic        no_idle = 1'b0;
	phase_t      enc_phase = PH_FIRST;
	logic [3:0]  enc_left = 4'd0;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		#(5_000_000);
		$display("FAILURE");
		$finish;
	end

	function automatic logic [7:0] enc_sym(input logic [5:0] idx);
		return ENC_TABLE[8 * (63 - int'(idx)) +: 8];
	endfunction

	function automatic int unsigned pause_len();
		return no_idle ? 0 : $urandom_range(0, 6);
	endfunction

	task automatic encode_byte(input logic [7:0] b, input logic last,
			output logic [31:0] chars, output int unsigned n);
		chars = 32'h0;
		n = 0;
		case (enc_phase)
			PH_SECOND: begin
				chars = {chars[23:0], enc_sym({enc_left[1:0], b[7:4]})};
				n++;
				enc_left = b[3:0];
				enc_phase = PH_THIRD;
				if (last) begin
					chars = {chars[23:0], enc_sym({b[3:0], 2'b00})};
					chars = {chars[23:0], PAD_CHAR};
					n += 2;
				end
			end
			PH_THIRD: begin
				chars = {chars[23:0], enc_sym({enc_left, b[7:6]})};
				chars = {chars[23:0], enc_sym(b[5:0])};
				n += 2;
				enc_left = 4'd0;
				enc_phase = PH_FIRST;
			end
			default: begin
				chars = {chars[23:0], enc_sym(b[7:2])};
				n++;
				enc_left = {2'b00, b[1:0]};
				enc_phase = PH_SECOND;
				if (last) begin
					chars = {chars[23:0], enc_sym({b[1:0], 4'b0000})};
					chars = {chars[23:0], PAD_CHAR};
					chars = {chars[23:0], PAD_CHAR};
					n += 3;
				end
			end
		endcase
		if (last) begin
			enc_phase = PH_FIRST;
			enc_left = 4'd0;
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last,
			input logic [2:0] known_n, input logic [31:0] known);
		int unsigned gap;
		logic [31:0] chars;
		int unsigned n;
		enc_char_t   rec;
		gap = pause_len();
		if (gap > 0) begin
			bytes_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		bytes_if.valid     <= 1'b1;
		bytes_if.data_byte <= b;
		bytes_if.last_byte <= last;
		do @(posedge clk); while (!bytes_if.ready);
		encode_byte(b, last, chars, n);
		if (known_n != 3'd0) begin
			chars = known;
			n = 32'(known_n);
		end
		for (int k = 0; k < n; k++) begin
			rec.ch = chars[8 * (n - 1 - k) +: 8];
			rec.last = last && (k == n - 1);
			pending_chars.push_back(rec);
		end
		@(negedge clk);
	endtask

	task automatic drain_chars();
		bytes_if.valid <= 1'b0;
		do @(negedge clk); while (pending_chars.size() != 0);
	endtask

	initial begin
		int unsigned stall;
		enc_char_t   exp_rec;
		chars_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = pause_len();
			if (stall > 0) begin
				chars_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			chars_if.ready <= 1'b1;
			do @(posedge clk); while (!chars_if.valid);
			if (pending_chars.size() == 0) begin
				$error("unexpected character transfer: out_char %h, out_last %b",
					chars_if.out_char, chars_if.out_last);
				mismatch_count++;
			end else begin
				exp_rec = pending_chars.pop_front();
				if (chars_if.out_char !== exp_rec.ch) begin
					$error("out_char: expected %h, actual %h", exp_rec.ch, chars_if.out_char);
					mismatch_count++;
				end
				if (chars_if.out_last !== exp_rec.last) begin
					$error("out_last: expected %b, actual %b", exp_rec.last, chars_if.out_last);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		int unsigned sent;
		int unsigned msg_len;
		logic [7:0]  b;
		bytes_if.valid = 1'b0;
		bytes_if.data_byte = 8'h00;
		bytes_if.last_byte = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < DIR_ROWS; r++)
			send_byte(MSG_TABLE[r].data, MSG_TABLE[r].last, MSG_TABLE[r].known_n,
				MSG_TABLE[r].known);
		drain_chars();

		sent = 0;
		while (sent < RANDOM_BYTES) begin
			no_idle = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 15) == 0)
				drain_chars();
			msg_len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 12);
			for (int i = 0; i < msg_len; i++) begin
				case ($urandom_range(0, 7))
					0: b = 8'h00;
					1: b = 8'hFF;
					default: b = 8'($urandom_range(0, 255));
				endcase
				send_byte(b, i == msg_len - 1, 3'd0, 32'h0);
			end
			sent += msg_len;
		end

		drain_chars();
		repeat (20) @(negedge clk);
		if (mismatch_count == 0 && pending_chars.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
